// ===== rtl/core/qppc_pkg.sv =====
// Package for the quadrature position controller: types, codes, widths and
// reset values shared by the interfaces, the register file, the arithmetic
// unit and the top level. Depends on nothing.
`timescale 1ns / 1ps

package qppc_pkg;

    // Widths of the datapath.
    localparam int POS_W    = 32;
    localparam int MAG_W    = POS_W + 1;
    localparam int GAIN_W   = 8;
    localparam int CPR_W    = 16;
    localparam int PROD_W   = MAG_W + GAIN_W;
    localparam int REM_W    = CPR_W + 1;
    localparam int PER_W    = 10;
    localparam int TICK_W   = 11;
    localparam int DUTY_W   = 8;
    localparam int STEP_W   = 6;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // Iteration counts of the shared unit.
    localparam int MUL_STEPS = GAIN_W;
    localparam int DIV_STEPS = PROD_W;

    // Reset values of the registers.
    localparam logic [POS_W-1:0]  RST_REFERENCE = 32'd2160;
    localparam logic [CPR_W-1:0]  RST_CPR       = 16'd216;
    localparam logic [GAIN_W-1:0] RST_GAIN      = 8'd10;
    localparam logic [PER_W-1:0]  RST_PERIOD    = 10'd5;
    localparam logic [DUTY_W-1:0] RST_DUTY_MAX  = 8'd100;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    // Event codes on the input channel.
    typedef enum logic [1:0] {
        OP_EDGE_A = 2'd0,
        OP_EDGE_B = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Register indexes, taken from the word address.
    typedef enum logic [2:0] {
        REG_REFERENCE = 3'd0,
        REG_CPR       = 3'd1,
        REG_GAIN      = 3'd2,
        REG_PERIOD    = 3'd3,
        REG_DUTY_MAX  = 3'd4
    } t_reg_idx;

    // Sequencer of the top level.
    typedef enum logic [1:0] {
        C_IDLE,
        C_CALC,
        C_EMIT
    } t_ctl_state;

    // Sequencer of the multiply-divide unit.
    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } t_unit_state;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [POS_W-1:0]  reference_counts;
        logic [CPR_W-1:0]  counts_per_rev;
        logic [GAIN_W-1:0] gain;
        logic [PER_W-1:0]  control_period;
        logic [DUTY_W-1:0] duty_max;
    } t_cfg;

    // Request to the multiply-divide unit.
    typedef struct packed {
        logic              start;
        logic [MAG_W-1:0]  mag;
        logic [GAIN_W-1:0] gain;
        logic [CPR_W-1:0]  divisor;
    } t_calc_req;

    // Response of the multiply-divide unit.
    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_calc_rsp;

endpackage

// ===== rtl/core/qppc_if.sv =====
// Valid/ready channel interfaces for the encoder events and the results.
// Depends on qppc_pkg for the field widths.
`timescale 1ns / 1ps

interface qppc_event_if;
    import qppc_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       level_a;
    logic       level_b;

    modport source (output valid, output operation, output level_a, output level_b,
                    input ready);
    modport sink   (input valid, input operation, input level_a, input level_b,
                    output ready);
endinterface

interface qppc_result_if;
    import qppc_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  position;
    logic [DUTY_W-1:0]        forward_duty;
    logic [DUTY_W-1:0]        reverse_duty;
    logic                     updated;

    modport source (output valid, output position, output forward_duty,
                    output reverse_duty, output updated, input ready);
    modport sink   (input valid, input position, input forward_duty,
                    input reverse_duty, input updated, output ready);
endinterface

// ===== rtl/core/qppc_regs.sv =====
// APB-style register file holding the five controller settings.
// Depends on qppc_pkg for the register codes, widths and reset values.
`timescale 1ns / 1ps

module qppc_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qppc_pkg::ADDR_W-1:0]  paddr,
    input  logic [qppc_pkg::DATA_W-1:0]  pwdata,
    output logic [qppc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output qppc_pkg::t_cfg               o_cfg
);
    import qppc_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Register writes in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reference_counts <= RST_REFERENCE;
            r_cfg.counts_per_rev   <= RST_CPR;
            r_cfg.gain             <= RST_GAIN;
            r_cfg.control_period   <= RST_PERIOD;
            r_cfg.duty_max         <= RST_DUTY_MAX;
        end else if (w_wr) begin
            case (w_idx)
                REG_REFERENCE: r_cfg.reference_counts <= pwdata[POS_W-1:0];
                REG_CPR:       r_cfg.counts_per_rev   <= pwdata[CPR_W-1:0];
                REG_GAIN:      r_cfg.gain             <= pwdata[GAIN_W-1:0];
                REG_PERIOD:    r_cfg.control_period   <= pwdata[PER_W-1:0];
                REG_DUTY_MAX:  r_cfg.duty_max         <= pwdata[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back, zero-extended.
    always_comb begin
        case (w_idx)
            REG_REFERENCE: prdata = r_cfg.reference_counts;
            REG_CPR:       prdata = {{(DATA_W-CPR_W){1'b0}}, r_cfg.counts_per_rev};
            REG_GAIN:      prdata = {{(DATA_W-GAIN_W){1'b0}}, r_cfg.gain};
            REG_PERIOD:    prdata = {{(DATA_W-PER_W){1'b0}}, r_cfg.control_period};
            REG_DUTY_MAX:  prdata = {{(DATA_W-DUTY_W){1'b0}}, r_cfg.duty_max};
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== rtl/core/qppc_muldiv.sv =====
// Iterative multiply-divide unit: shift-add multiply of the error magnitude
// by the gain, then restoring division by counts per revolution, all on one
// shared adder. Depends on qppc_pkg.
`timescale 1ns / 1ps

module qppc_muldiv (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  qppc_pkg::t_calc_req i_req,
    output qppc_pkg::t_calc_rsp o_rsp
);
    import qppc_pkg::*;

    t_unit_state       r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic              r_done, n_done;
    logic [MAG_W-1:0]  r_mag, n_mag;
    logic [GAIN_W-1:0] r_gain, n_gain;
    logic [CPR_W-1:0]  r_div, n_div;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [PROD_W-1:0] r_quo, n_quo;
    logic [REM_W-1:0]  r_rem, n_rem;

    // Shared adder operands and result.
    logic              w_sub;
    logic [PROD_W-1:0] w_op_a, w_op_b;
    logic [PROD_W:0]   w_sum;
    logic [REM_W-1:0]  w_rem_sh;

    assign w_rem_sh = {r_rem[REM_W-2:0], r_acc[PROD_W-1]};
    assign w_sub    = (r_state == U_DIV);

    always_comb begin
        if (w_sub) begin
            w_op_a = {{(PROD_W-REM_W){1'b0}}, w_rem_sh};
            w_op_b = {{(PROD_W-CPR_W){1'b0}}, r_div};
        end else begin
            w_op_a = {r_acc[PROD_W-2:0], 1'b0};
            w_op_b = r_gain[r_cnt[2:0]] ? {{(PROD_W-MAG_W){1'b0}}, r_mag} : '0;
        end
    end

    // Bit PROD_W is the carry: on a subtract it means no borrow.
    assign w_sum = {1'b0, w_op_a} + {1'b0, w_op_b ^ {PROD_W{w_sub}}}
                 + {{PROD_W{1'b0}}, w_sub};

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
    end

    // Operand and working registers.
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_gain <= n_gain;
        r_div  <= n_div;
        r_acc  <= n_acc;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
    end

    // Sequencer: load, multiply steps, divide steps.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_mag   = r_mag;
        n_gain  = r_gain;
        n_div   = r_div;
        n_acc   = r_acc;
        n_quo   = r_quo;
        n_rem   = r_rem;
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    n_mag   = i_req.mag;
                    n_gain  = i_req.gain;
                    n_div   = i_req.divisor;
                    n_acc   = '0;
                    n_cnt   = STEP_W'(MUL_STEPS - 1);
                    n_state = U_MUL;
                end
            end
            U_MUL: begin
                // Gain bits from the top down: acc = 2*acc + bit*mag.
                n_acc = w_sum[PROD_W-1:0];
                if (r_cnt == '0) begin
                    n_cnt   = STEP_W'(DIV_STEPS - 1);
                    n_rem   = '0;
                    n_quo   = '0;
                    n_state = U_DIV;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            U_DIV: begin
                // One quotient bit per step, product bits shifted in from the top.
                n_acc = {r_acc[PROD_W-2:0], 1'b0};
                n_rem = w_sum[PROD_W] ? w_sum[REM_W-1:0] : w_rem_sh;
                n_quo = {r_quo[PROD_W-2:0], w_sum[PROD_W]};
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = U_IDLE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_state = U_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/quadrature_position_p_controller.sv =====
// Top level of the quadrature position controller: event sequencer, position
// and tick counters, duty registers and result register. Depends on qppc_pkg,
// qppc_if, qppc_regs and qppc_muldiv.
//
//  Channel  | Dir | Handshake          | Contents
//  ---------+-----+--------------------+------------------------------------------
//  i_cmd    | in  | valid/ready        | operation, level_a, level_b
//  o_res    | out | valid/ready        | position, forward_duty, reverse_duty, updated
//  APB      | in  | psel/penable/pready| five settings at byte addresses 0,4,...,16
//
// An edge event, an unused code or a tick without update goes to C_EMIT and
// from there into the output register once that is free. A tick that runs the
// control update first waits in C_CALC for the multiply-divide unit: 8 multiply
// steps and 41 divide steps on its shared adder. One event is in work at a time;
// the next one is taken while the previous result still waits in the output register.
// Reset is synchronous, clears counters and duties, and restores the settings.
`timescale 1ns / 1ps

module quadrature_position_p_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    qppc_event_if.sink                   i_cmd,
    qppc_result_if.source                o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qppc_pkg::ADDR_W-1:0]  paddr,
    input  logic [qppc_pkg::DATA_W-1:0]  pwdata,
    output logic [qppc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import qppc_pkg::*;

    t_cfg              w_cfg;
    t_calc_req         w_req;
    t_calc_rsp         w_rsp;

    t_ctl_state        r_state, n_state;
    logic [POS_W-1:0]  r_position, n_position;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;
    logic [DUTY_W-1:0] r_fwd, n_fwd;
    logic [DUTY_W-1:0] r_rev, n_rev;
    logic              r_upd, n_upd;
    logic              r_err_pos, n_err_pos;
    logic              r_out_valid, n_out_valid;
    logic [POS_W-1:0]  r_out_position;
    logic [DUTY_W-1:0] r_out_fwd, r_out_rev;
    logic              r_out_upd;
    logic              w_load;
    logic              w_start;

    // Error terms, both directions computed side by side.
    logic [MAG_W-1:0]  w_ref_ext, w_pos_ext, w_d_pos, w_d_neg;
    logic              w_err_neg, w_err_zero;
    logic [TICK_W-1:0] w_tick_inc;
    logic              w_fire, w_up;
    logic [DUTY_W-1:0] w_clamped;
    t_op               w_op;

    qppc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    qppc_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign i_cmd.ready = (r_state == C_IDLE);
    assign w_fire      = i_cmd.valid && i_cmd.ready;
    assign w_op        = t_op'(i_cmd.operation);

    assign w_ref_ext  = {w_cfg.reference_counts[POS_W-1], w_cfg.reference_counts};
    assign w_pos_ext  = {r_position[POS_W-1], r_position};
    assign w_d_pos    = w_ref_ext - w_pos_ext;
    assign w_d_neg    = w_pos_ext - w_ref_ext;
    assign w_err_neg  = w_d_pos[MAG_W-1];
    assign w_err_zero = (w_d_pos == '0);

    assign w_tick_inc = (r_elapsed != TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;

    // Quadrature direction: A counts up on unequal levels, B on equal levels.
    assign w_up = (w_op == OP_EDGE_A) ? (i_cmd.level_a != i_cmd.level_b)
                                      : (i_cmd.level_a == i_cmd.level_b);

    assign w_clamped = (w_rsp.quotient > {{(PROD_W-DUTY_W){1'b0}}, w_cfg.duty_max})
                     ? w_cfg.duty_max : w_rsp.quotient[DUTY_W-1:0];

    assign w_req.start   = w_start;
    assign w_req.mag     = w_err_neg ? w_d_neg : w_d_pos;
    assign w_req.gain    = w_cfg.gain;
    assign w_req.divisor = (w_cfg.counts_per_rev == '0) ? CPR_W'(1)
                                                       : w_cfg.counts_per_rev;

    assign o_res.valid        = r_out_valid;
    assign o_res.position     = r_out_position;
    assign o_res.forward_duty = r_out_fwd;
    assign o_res.reverse_duty = r_out_rev;
    assign o_res.updated      = r_out_upd;

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_position  <= '0;
            r_elapsed   <= '0;
            r_fwd       <= '0;
            r_rev       <= '0;
            r_upd       <= 1'b0;
            r_err_pos   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_position  <= n_position;
            r_elapsed   <= n_elapsed;
            r_fwd       <= n_fwd;
            r_rev       <= n_rev;
            r_upd       <= n_upd;
            r_err_pos   <= n_err_pos;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_position <= r_position;
            r_out_fwd      <= r_fwd;
            r_out_rev      <= r_rev;
            r_out_upd      <= r_upd;
        end
    end

    // Event sequencer.
    always_comb begin
        n_state     = r_state;
        n_position  = r_position;
        n_elapsed   = r_elapsed;
        n_fwd       = r_fwd;
        n_rev       = r_rev;
        n_upd       = r_upd;
        n_err_pos   = r_err_pos;
        n_out_valid = r_out_valid && !o_res.ready;
        w_load      = 1'b0;
        w_start     = 1'b0;
        case (r_state)
            C_IDLE: begin
                if (w_fire) begin
                    n_upd   = 1'b0;
                    n_state = C_EMIT;
                    case (w_op)
                        OP_EDGE_A, OP_EDGE_B: begin
                            n_position = r_position + (w_up ? POS_W'(1) : {POS_W{1'b1}});
                        end
                        OP_TICK: begin
                            if (w_tick_inc > {1'b0, w_cfg.control_period}) begin
                                n_elapsed   = '0;
                                n_upd       = 1'b1;
                                n_err_pos   = !w_err_neg && !w_err_zero;
                                w_start     = 1'b1;
                                n_state     = C_CALC;
                            end else begin
                                n_elapsed = w_tick_inc;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            C_CALC: begin
                // Positive error drives forward, otherwise reverse.
                if (w_rsp.done) begin
                    n_fwd   = r_err_pos ? w_clamped : '0;
                    n_rev   = r_err_pos ? '0 : w_clamped;
                    n_state = C_EMIT;
                end
            end
            C_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/qppc_checker.sv =====
// Port-level checks for the quadrature position controller, and the bind
// that attaches them to the top level. Depends on qppc_pkg.
`timescale 1ns / 1ps

module qppc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [qppc_pkg::POS_W-1:0]    i_position,
    input  logic [qppc_pkg::DUTY_W-1:0]   i_forward_duty,
    input  logic [qppc_pkg::DUTY_W-1:0]   i_reverse_duty,
    input  logic                          i_updated
);
    import qppc_pkg::*;

    // Only one drive direction is ever active.
    a_one_direction: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_forward_duty == '0 || i_reverse_duty == '0))
        else $error("both drive duties nonzero");

    // One event at a time: an input transfer closes the input side.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an event is in work");

    // A stalled result holds its contents.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_position)
            && $stable(i_forward_duty) && $stable(i_reverse_duty) && $stable(i_updated)))
        else $error("stalled result changed");

    // Nothing is offered in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result offered right after reset");

endmodule

bind quadrature_position_p_controller qppc_checker u_qppc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_cmd.valid),
    .i_in_ready     (i_cmd.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_position     (o_res.position),
    .i_forward_duty (o_res.forward_duty),
    .i_reverse_duty (o_res.reverse_duty),
    .i_updated      (o_res.updated)
);
